[src/p2ll_pkg.sv]
// shared types, constants and constant tables for the pixel to lat/lon converter
package p2ll_pkg;

  localparam int unsigned ZOOM_MAX         = 20;
  localparam int unsigned TILE_PIXELS_LOG2 = 8;
  localparam int unsigned CORDIC_STEPS     = 28;

  // inner word widths
  localparam int unsigned TW = 36;  // reduced argument, hyperbolic words, angle
  localparam int unsigned VW = 44;  // circular vectoring words

  typedef struct packed {
    logic [27:0] pixel_x;
    logic [27:0] pixel_y;
    logic [4:0]  zoom_level;
  } pix_req_t;

  typedef struct packed {
    logic signed [32:0] longitude_deg;
    logic signed [31:0] latitude_deg;
    logic               was_clamped;
  } geo_res_t;

  // values that ride alongside the latitude path
  typedef struct packed {
    logic signed [32:0] longitude_deg;
    logic               was_clamped;
  } side_t;

  // shift and subtract quotient, only evaluated while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] series_pow2(input int unsigned i, input bit alt);
    logic [63:0]        p;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int unsigned        n;
    int unsigned        s;
    sum = '0;
    n   = 0;
    while (i * (2 * n + 1) <= 60) begin
      s    = i * (2 * n + 1);
      p    = (64'd1 << 60) >> s;
      term = $signed(udiv64(p, 64'(2 * n + 1)));
      if (alt && n[0]) sum = sum - term;
      else sum = sum + term;
      n++;
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] series_recip(input logic [63:0] m, input bit alt);
    logic [63:0]        p;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int unsigned        n;
    p   = udiv64(64'd1 << 60, m);
    sum = '0;
    n   = 0;
    while (p != 64'd0) begin
      term = $signed(udiv64(p, 64'(2 * n + 1)));
      if (alt && n[0]) sum = sum - term;
      else sum = sum + term;
      p = udiv64(p, m * m);
      n++;
    end
    return sum;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    n   = v;
    res = '0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] q60_to_q32(input logic signed [63:0] v);
    return (v + (64'sd1 <<< 27)) >>> 28;
  endfunction

  // hyperbolic shift schedule with repeats at 4, 13, 40
  function automatic int unsigned hyp_shift(input int unsigned j);
    int unsigned i;
    int unsigned rep;
    bit          repeated;
    int unsigned jj;
    i        = 1;
    rep      = 4;
    repeated = 1'b0;
    for (jj = 0; jj < j; jj++) begin
      if (i == rep && !repeated) begin
        repeated = 1'b1;
      end else begin
        if (i == rep) begin
          rep      = 3 * rep + 1;
          repeated = 1'b0;
        end
        i++;
      end
    end
    return i;
  endfunction

  localparam logic signed [63:0] PI_Q60 =
      64'sd4 * (64'sd4 * series_recip(64'd5, 1'b1) - series_recip(64'd239, 1'b1));
  localparam logic signed [63:0] PI_Q32      = q60_to_q32(PI_Q60);
  localparam logic signed [63:0] HALF_PI_Q32 = (PI_Q60 + (64'sd1 <<< 28)) >>> 29;
  localparam logic signed [63:0] LN2_Q32     = q60_to_q32(64'sd2 * series_recip(64'd3, 1'b0));
  localparam logic signed [63:0] HALF_LN2    = LN2_Q32 >>> 1;
  localparam logic [63:0] RAD2DEG_Q24 =
      ((64'd180 << 56) + $unsigned(PI_Q32) / 64'd2) / $unsigned(PI_Q32);
  localparam logic signed [63:0] LAT_LIMIT   = 64'sd1434451968;

  function automatic logic [63:0] gain_q32_f();
    logic [63:0] prod;
    int unsigned jj;
    int unsigned i;
    prod = 64'd1 << 60;
    for (jj = 0; jj < CORDIC_STEPS; jj++) begin
      i = hyp_shift(jj);
      if (2 * i < 64) prod = prod - (prod >> (2 * i));
    end
    return isqrt64(prod << 4);
  endfunction

  localparam logic [63:0] GAIN_Q32 = gain_q32_f();

  function automatic logic signed [63:0] atan_q32(input int unsigned j);
    if (j == 0) return (PI_Q60 + (64'sd1 <<< 29)) >>> 30;
    return q60_to_q32(series_pow2(j, 1'b1));
  endfunction

  function automatic logic signed [63:0] atanh_q32(input int unsigned j);
    return q60_to_q32(series_pow2(hyp_shift(j), 1'b0));
  endfunction

  // bound above which range reduction takes another ln2
  function automatic logic signed [63:0] ln2_thresh(input int unsigned j);
    return HALF_LN2 + 64'(j) * LN2_Q32;
  endfunction

endpackage

[src/p2ll_front.sv]
// clamp, longitude and the scaled mercator argument t (four stages)
module p2ll_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  p2ll_pkg::pix_req_t                  req_i,
  output logic                                valid_o,
  output logic signed [p2ll_pkg::TW-1:0]      t_o,
  output p2ll_pkg::side_t                     side_o
);

  localparam logic signed [35:0] PI36 = 36'(p2ll_pkg::PI_Q32);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [28:0] x1_q, y1_q;
  logic [4:0]  s1_q;
  logic        c1_q;

  logic [4:0]  zc, s;
  logic [28:0] w, xe, ye;

  always_comb begin
    zc = (req_i.zoom_level > 5'(p2ll_pkg::ZOOM_MAX)) ? 5'(p2ll_pkg::ZOOM_MAX)
                                                     : req_i.zoom_level;
    s  = 5'(p2ll_pkg::TILE_PIXELS_LOG2) + zc;
    w  = 29'd1 << s;
    xe = {1'b0, req_i.pixel_x};
    ye = {1'b0, req_i.pixel_y};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= (xe > w) ? w : xe;
      y1_q <= (ye > w) ? w : ye;
      s1_q <= s;
      c1_q <= (xe > w) || (ye > w);
    end
  end

  // stage 2: longitude and f = (w - 2y) * 2^40 / w
  logic [37:0]        num, numsh;
  logic signed [33:0] lon_w;
  logic [28:0]        w1;
  logic signed [30:0] d;
  logic signed [41:0] f;
  p2ll_pkg::side_t    side2_q, side3_q;
  logic signed [21:0] fh2_q;
  logic [19:0]        fl2_q;

  always_comb begin
    num = 38'(x1_q) * 38'd360;
    if (s1_q <= 5'd24) numsh = num << (5'd24 - s1_q);
    else numsh = (num + (38'd1 << (s1_q - 5'd25))) >> (s1_q - 5'd24);
    lon_w = $signed({1'b0, numsh[32:0]}) - 34'sd3019898880;
    w1    = 29'd1 << s1_q;
    d     = $signed({2'b00, w1}) - $signed({1'b0, y1_q, 1'b0});
    f     = $signed({{11{d[30]}}, d}) <<< (6'd40 - 6'(s1_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q.longitude_deg <= lon_w[32:0];
      side2_q.was_clamped   <= c1_q;
      fh2_q                 <= f[41:20];
      fl2_q                 <= f[19:0];
    end
  end

  // stage 3: the two partial products of pi * f
  logic signed [57:0] phi3_q;
  logic signed [56:0] plo3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi3_q  <= PI36 * fh2_q;
      plo3_q  <= PI36 * $signed({1'b0, fl2_q});
      side3_q <= side2_q;
    end
  end

  // stage 4: recombine
  logic signed [58:0] tsum;

  always_comb begin
    tsum = $signed({phi3_q[57], phi3_q}) + 59'(plo3_q >>> 20);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_o    <= tsum[55:20];
      side_o <= side3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
    end
  end

  assign valid_o = v4_q;

endmodule

[src/p2ll_hyp.sv]
// ln2 range reduction and hyperbolic rotation giving the vectoring start point
module p2ll_hyp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [p2ll_pkg::TW-1:0]      t_i,
  input  p2ll_pkg::side_t                     side_i,
  output logic                                valid_o,
  output logic signed [p2ll_pkg::VW-1:0]      vx_o,
  output logic signed [p2ll_pkg::VW-1:0]      vy_o,
  output p2ll_pkg::side_t                     side_o
);

  localparam int unsigned N  = p2ll_pkg::CORDIC_STEPS;
  localparam int unsigned TW = p2ll_pkg::TW;
  localparam int unsigned VW = p2ll_pkg::VW;
  localparam logic signed [TW-1:0] LN2 = TW'(p2ll_pkg::LN2_Q32);
  localparam logic signed [VW-1:0] GAIN = VW'($signed(p2ll_pkg::GAIN_Q32));

  // stage a: count of ln2 steps
  logic              va_q;
  logic signed [TW-1:0] ta_q;
  logic signed [3:0] ka_q;
  p2ll_pkg::side_t   sidea_q;
  logic [2:0]        kp, kn;

  always_comb begin
    kp = '0;
    kn = '0;
    for (int unsigned j = 0; j < 5; j++) begin
      if (t_i > TW'(p2ll_pkg::ln2_thresh(j)))  kp = kp + 3'd1;
      if (t_i < -TW'(p2ll_pkg::ln2_thresh(j))) kn = kn + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q    <= t_i;
      ka_q    <= $signed({1'b0, kp}) - $signed({1'b0, kn});
      sidea_q <= side_i;
    end
  end

  // stage b: residual, seeds the rotation
  logic signed [TW-1:0] hx_q [N+1];
  logic signed [TW-1:0] hy_q [N+1];
  logic signed [TW-1:0] hz_q [N+1];
  logic signed [3:0]    k_q  [N+1];
  p2ll_pkg::side_t      sd_q [N+1];
  logic                 v_q  [N+1];
  logic signed [TW+3:0] kmul, rw;

  always_comb begin
    kmul = ka_q * LN2;
    rw   = $signed({{4{ta_q[TW-1]}}, ta_q}) - kmul;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hx_q[0] <= TW'(64'sd1 <<< 32);
      hy_q[0] <= '0;
      hz_q[0] <= rw[TW-1:0];
      k_q[0]  <= ka_q;
      sd_q[0] <= sidea_q;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_rot
    localparam int unsigned        SH  = p2ll_pkg::hyp_shift(j);
    localparam logic signed [TW-1:0] ATH = TW'(p2ll_pkg::atanh_q32(j));
    logic signed [TW-1:0] dx, dy;
    assign dx = hy_q[j] >>> SH;
    assign dy = hx_q[j] >>> SH;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!hz_q[j][TW-1]) begin
          hx_q[j+1] <= hx_q[j] + dx;
          hy_q[j+1] <= hy_q[j] + dy;
          hz_q[j+1] <= hz_q[j] - ATH;
        end else begin
          hx_q[j+1] <= hx_q[j] - dx;
          hy_q[j+1] <= hy_q[j] - dy;
          hz_q[j+1] <= hz_q[j] + ATH;
        end
        k_q[j+1]  <= k_q[j];
        sd_q[j+1] <= sd_q[j];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[j+1] <= 1'b0;
      else if (en_i) v_q[j+1] <= v_q[j];
    end
  end

  // stage e: exp(r) scaled by 2^k against the gain
  logic signed [TW:0]   e;
  logic signed [VW-1:0] e_w;
  logic signed [3:0]    kneg;

  always_comb begin
    e    = $signed({hx_q[N][TW-1], hx_q[N]}) + $signed({hy_q[N][TW-1], hy_q[N]});
    e_w  = VW'(e);
    kneg = -k_q[N];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!k_q[N][3]) begin
        vy_o <= e_w <<< k_q[N][2:0];
        vx_o <= GAIN;
      end else begin
        vy_o <= e_w;
        vx_o <= GAIN <<< kneg[2:0];
      end
      side_o <= sd_q[N];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      v_q[0]  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      v_q[0]  <= va_q;
      valid_o <= v_q[N];
    end
  end

endmodule

[src/p2ll_vec.sv]
// circular vectoring for atan, then scaling to degrees into the result register
module p2ll_vec (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [p2ll_pkg::VW-1:0]      vx_i,
  input  logic signed [p2ll_pkg::VW-1:0]      vy_i,
  input  p2ll_pkg::side_t                     side_i,
  output logic                                valid_o,
  output p2ll_pkg::geo_res_t                  res_o
);

  localparam int unsigned N  = p2ll_pkg::CORDIC_STEPS;
  localparam int unsigned TW = p2ll_pkg::TW;
  localparam int unsigned VW = p2ll_pkg::VW;
  localparam logic signed [37:0] HALF_PI = 38'(p2ll_pkg::HALF_PI_Q32);
  localparam logic signed [31:0] RAD2DEG = $signed({1'b0, p2ll_pkg::RAD2DEG_Q24[30:0]});
  localparam logic signed [37:0] LIM     = 38'(p2ll_pkg::LAT_LIMIT);

  logic signed [VW-1:0] vx_q  [N];
  logic signed [VW-1:0] vy_q  [N];
  logic signed [TW-1:0] ang_q [N];
  p2ll_pkg::side_t      sd_q  [N];
  logic                 v_q   [N];

  for (genvar j = 0; j < N; j++) begin : g_vec
    localparam logic signed [TW-1:0] AT = TW'(p2ll_pkg::atan_q32(j));
    logic signed [VW-1:0] cx, cy, dx, dy;
    logic signed [TW-1:0] ca;
    p2ll_pkg::side_t      cs;
    logic                 cv;
    if (j == 0) begin : g_first
      assign cx = vx_i;
      assign cy = vy_i;
      assign ca = '0;
      assign cs = side_i;
      assign cv = valid_i;
    end else begin : g_next
      assign cx = vx_q[j-1];
      assign cy = vy_q[j-1];
      assign ca = ang_q[j-1];
      assign cs = sd_q[j-1];
      assign cv = v_q[j-1];
    end
    assign dx = cy >>> j;
    assign dy = cx >>> j;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy[VW-1]) begin
          vx_q[j]  <= cx + dx;
          vy_q[j]  <= cy - dy;
          ang_q[j] <= ca + AT;
        end else begin
          vx_q[j]  <= cx - dx;
          vy_q[j]  <= cy + dy;
          ang_q[j] <= ca - AT;
        end
        sd_q[j] <= cs;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[j] <= 1'b0;
      else if (en_i) v_q[j] <= cv;
    end
  end

  // scale 2*atan - pi/2 to degrees
  logic signed [37:0] lat_r;
  logic signed [69:0] prod_q;
  p2ll_pkg::side_t    sdm_q;
  logic               vm_q;

  always_comb begin
    lat_r = $signed({ang_q[N-1][TW-1], ang_q[N-1], 1'b0}) - HALF_PI;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= lat_r * RAD2DEG;
      sdm_q  <= sd_q[N-1];
    end
  end

  logic signed [69:0] rnd;
  logic signed [37:0] lat_d;

  always_comb begin
    rnd   = prod_q + (70'sd1 <<< 31);
    lat_d = rnd[69:32];
    if (lat_d > LIM) lat_d = LIM;
    if (lat_d < -LIM) lat_d = -LIM;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.longitude_deg <= sdm_q.longitude_deg;
      res_o.latitude_deg  <= lat_d[31:0];
      res_o.was_clamped   <= sdm_q.was_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vm_q    <= v_q[N-1];
      valid_o <= vm_q;
    end
  end

endmodule

[src/pixel_to_lat_lon_top.sv]
// top level of the web mercator pixel to longitude/latitude converter
// throughput: one request per cycle while not stalled; the 28-step hyperbolic and 28-step
// circular cordic pipelines each hold one iteration per stage
// a stalled result freezes the whole pipeline, so nothing is lost or repeated
// reset clears the valid bits only; all tables are constants, no clearing pass
module pixel_to_lat_lon_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  p2ll_pkg::pix_req_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output p2ll_pkg::geo_res_t    out_data_o
);

  // global advance: every stage moves unless the result register is held
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // front end: clamp, longitude, mercator argument t
  logic                              f_valid;
  logic signed [p2ll_pkg::TW-1:0]    f_t;
  p2ll_pkg::side_t                   f_side;

  p2ll_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_data_i),
    .valid_o (f_valid),
    .t_o     (f_t),
    .side_o  (f_side)
  );

  // exp(t) by ln2 reduction and hyperbolic rotation
  logic                              h_valid;
  logic signed [p2ll_pkg::VW-1:0]    h_vx, h_vy;
  p2ll_pkg::side_t                   h_side;

  p2ll_hyp u_hyp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .t_i     (f_t),
    .side_i  (f_side),
    .valid_o (h_valid),
    .vx_o    (h_vx),
    .vy_o    (h_vy),
    .side_o  (h_side)
  );

  // atan by vectoring, degrees, result register
  p2ll_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_valid),
    .vx_i    (h_vx),
    .vy_i    (h_vy),
    .side_i  (h_side),
    .valid_o (out_valid_o),
    .res_o   (out_data_o)
  );

endmodule

[bench/tb_top.sv]
// testbench for the web mercator pixel to longitude/latitude converter
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned ZOOM_TOP   = 20;
  localparam int unsigned TILE_LOG2  = 8;
  localparam int unsigned STEPS      = 28;
  localparam int unsigned N_RANDOM   = 1650;
  localparam int unsigned DRAIN_WAIT = 200;   // well above the pipeline latency

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  p2ll_pkg::pix_req_t in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  p2ll_pkg::geo_res_t out_data_o;

  pixel_to_lat_lon_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // requests waiting to be driven, and geo results waiting to come out
  p2ll_pkg::pix_req_t pending_reqs[$];
  p2ll_pkg::geo_res_t expected_geo[$];
  int unsigned mismatches = 0;

  // constant tables, built once at time zero
  longint      atan_rad[STEPS];
  longint      atanh_rad[STEPS];
  int unsigned hyp_sh[STEPS];
  longint      pi_fx, half_pi_fx, ln2_fx, gain_fx, deg_per_rad;

  // arc tangent (alt) or hyperbolic arc tangent of 2^-sh, 60 fraction bits
  function automatic longint arctan_pow2(int unsigned sh, bit alt);
    longint acc;
    longint part;
    int unsigned n;
    acc = 0;
    n   = 0;
    while (sh * (2 * n + 1) <= 60) begin
      part = longint'((64'd1 << 60) >> (sh * (2 * n + 1))) / longint'(2 * n + 1);
      acc  = (alt && n[0]) ? acc - part : acc + part;
      n++;
    end
    return acc;
  endfunction

  // arc tangent (alt) or hyperbolic arc tangent of 1/m, 60 fraction bits
  function automatic longint arctan_recip(longint unsigned m, bit alt);
    longint unsigned pw;
    longint part;
    longint acc;
    int unsigned n;
    pw  = (64'd1 << 60) / m;
    acc = 0;
    n   = 0;
    while (pw != 0) begin
      part = longint'(pw / longint'(2 * n + 1));
      acc  = (alt && n[0]) ? acc - part : acc + part;
      pw   = pw / (m * m);
      n++;
    end
    return acc;
  endfunction

  function automatic longint to_q32(longint v);
    return (v + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b    = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v    = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  task automatic build_tables();
    longint          pi60;
    longint unsigned prod;
    int unsigned     sh;
    int unsigned     rep;
    bit              again;
    pi60        = 4 * (4 * arctan_recip(5, 1'b1) - arctan_recip(239, 1'b1));
    pi_fx       = to_q32(pi60);
    half_pi_fx  = (pi60 + (64'sd1 <<< 28)) >>> 29;
    ln2_fx      = to_q32(2 * arctan_recip(3, 1'b0));
    deg_per_rad = longint'(((64'd180 << 56) + longint'(unsigned'(pi_fx)) / 2)
                  / longint'(pi_fx));
    prod  = 64'd1 << 60;
    sh    = 1;
    rep   = 4;
    again = 1'b0;
    for (int j = 0; j < STEPS; j++) begin
      atan_rad[j]  = (j == 0) ? ((pi60 + (64'sd1 <<< 29)) >>> 30)
                              : to_q32(arctan_pow2(j, 1'b1));
      hyp_sh[j]    = sh;
      atanh_rad[j] = to_q32(arctan_pow2(sh, 1'b0));
      if (2 * sh < 64) prod = prod - (prod >> (2 * sh));
      // shifts 4 and 13 are taken twice for convergence
      if (sh == rep && !again) begin
        again = 1'b1;
      end else begin
        if (sh == rep) begin
          rep   = 3 * rep + 1;
          again = 1'b0;
        end
        sh++;
      end
    end
    gain_fx = longint'(int_sqrt(prod << 4));
  endtask

  // geo result for one pixel request
  function automatic p2ll_pkg::geo_res_t pixel_to_geo(p2ll_pkg::pix_req_t req);
    p2ll_pkg::geo_res_t res;
    longint unsigned    px, py, zm, w, num;
    int unsigned        s;
    int                 k;
    longint             lon, d, f, fh, fl, t, r, hx, hy, hz, dx, dy, e, vx, vy, ang, lat;
    px  = req.pixel_x;
    py  = req.pixel_y;
    zm  = req.zoom_level;
    res = '0;
    k   = 0;
    if (zm > ZOOM_TOP) zm = ZOOM_TOP;   // zoom beyond the limit is quietly capped
    s = TILE_LOG2 + int'(zm);
    w = 64'd1 << s;
    // beyond the map edge is pulled back onto it; the edge itself is no clamp
    if (px > w) begin px = w; res.was_clamped = 1'b1; end
    if (py > w) begin py = w; res.was_clamped = 1'b1; end

    num = px * 360;
    if (s <= 24) num = num << (24 - s);
    else num = (num + (64'd1 << (s - 25))) >> (s - 24);
    lon = longint'(num) - (64'sd180 <<< 24);
    res.longitude_deg = lon[32:0];

    // mercator argument t = pi * (1 - 2y/w), split multiply keeps 64 bits
    d  = longint'(w) - 2 * longint'(py);
    f  = d * (64'sd1 <<< (40 - s));
    fh = f >>> 20;
    fl = f - fh * (64'sd1 <<< 20);
    t  = (pi_fx * fh + ((pi_fx * fl) >>> 20)) >>> 20;

    // exp(t) = 2^k * exp(r)
    r = t;
    for (int j = 0; j < 16; j++) begin
      if (r > (ln2_fx >>> 1)) begin r -= ln2_fx; k++; end
      else if (r < -(ln2_fx >>> 1)) begin r += ln2_fx; k--; end
    end
    hx = 64'sd1 <<< 32;
    hy = 0;
    hz = r;
    for (int j = 0; j < STEPS; j++) begin
      dx = hy >>> hyp_sh[j];
      dy = hx >>> hyp_sh[j];
      if (hz >= 0) begin hx += dx; hy += dy; hz -= atanh_rad[j]; end
      else begin hx -= dx; hy -= dy; hz += atanh_rad[j]; end
    end
    e = hx + hy;

    // atan(exp(t)) by vectoring, cordic gain folded into x
    if (k >= 0) begin vy = e * (64'sd1 <<< k); vx = gain_fx; end
    else begin vy = e; vx = gain_fx * (64'sd1 <<< (-k)); end
    ang = 0;
    for (int j = 0; j < STEPS; j++) begin
      dx = vy >>> j;
      dy = vx >>> j;
      if (vy >= 0) begin vx += dx; vy -= dy; ang += atan_rad[j]; end
      else begin vx -= dx; vy += dy; ang -= atan_rad[j]; end
    end

    lat = 2 * ang - half_pi_fx;
    lat = (lat * deg_per_rad + (64'sd1 <<< 31)) >>> 32;
    if (lat > 64'sd1434451968) lat = 64'sd1434451968;
    if (lat < -64'sd1434451968) lat = -64'sd1434451968;
    res.latitude_deg = lat[31:0];
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // gap or stall length; bursts with none at all come in stretches
  bit no_idle_in = 1'b0;
  bit no_idle_out = 1'b0;
  function automatic int unsigned idle_draw(bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  // pixel coordinate for a map w wide: mostly on the map, some on or past the edge
  function automatic logic [27:0] coord_draw(longint unsigned w);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 28'($urandom_range(0, int'(w)));
    if (pick < 78) return 28'(w);
    if (pick < 85) return 28'(w + 1);
    return 28'($urandom);
  endfunction

  // request driver
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit                 held;
    logic               nxt_valid;
    p2ll_pkg::pix_req_t nxt_data;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_data  = in_data_i;
      held      = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_geo.push_back(pixel_to_geo(in_data_i));
        held = 1'b0;
      end
      if (!held) begin
        nxt_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() > 0) begin
          nxt_data  = pending_reqs.pop_front();
          nxt_valid = 1'b1;
          if ($urandom_range(0, 49) == 0) no_idle_in = ~no_idle_in;
          in_gap = idle_draw(no_idle_in);
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i  <= nxt_data;
    end
  end

  // result monitor and stall generator
  int unsigned out_hold = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    p2ll_pkg::geo_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_geo.size() == 0) begin
          report("unexpected result, longitude", out_data_o.longitude_deg, 0);
        end else begin
          want = expected_geo.pop_front();
          if (out_data_o.longitude_deg !== want.longitude_deg)
            report("longitude", out_data_o.longitude_deg, want.longitude_deg);
          if (out_data_o.latitude_deg !== want.latitude_deg)
            report("latitude", out_data_o.latitude_deg, want.latitude_deg);
          if (out_data_o.was_clamped !== want.was_clamped)
            report("clamp flag", out_data_o.was_clamped, want.was_clamped);
        end
        if ($urandom_range(0, 49) == 0) no_idle_out = ~no_idle_out;
        out_hold = idle_draw(no_idle_out);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // stimulus and end of run
  initial begin
    p2ll_pkg::pix_req_t req;
    longint unsigned    w;
    int unsigned        zpick;
    build_tables();

    // directed: every fourth zoom at two opposite corners and the centre, then points past the edge
    for (int z = 0; z <= 20; z += 4) begin
      w = 64'd1 << (TILE_LOG2 + z);
      pending_reqs.push_back('{pixel_x: 28'(0), pixel_y: 28'(0), zoom_level: 5'(z)});
      pending_reqs.push_back('{pixel_x: 28'(w), pixel_y: 28'(w), zoom_level: 5'(z)});
      pending_reqs.push_back('{pixel_x: 28'(w / 2), pixel_y: 28'(w / 2), zoom_level: 5'(z)});
    end
    pending_reqs.push_back('{pixel_x: 28'(257), pixel_y: 28'(1), zoom_level: 5'd0});
    pending_reqs.push_back('{pixel_x: 28'(3), pixel_y: 28'(300), zoom_level: 5'd0});
    pending_reqs.push_back('{pixel_x: 28'hFFFFFFF, pixel_y: 28'hFFFFFFF, zoom_level: 5'd20});
    pending_reqs.push_back('{pixel_x: 28'hFFFFFFF, pixel_y: 28'h0, zoom_level: 5'd19});
    pending_reqs.push_back('{pixel_x: 28'd12345, pixel_y: 28'd54321, zoom_level: 5'd21});
    pending_reqs.push_back('{pixel_x: 28'hABCDEF1, pixel_y: 28'h1234567, zoom_level: 5'd31});
    pending_reqs.push_back('{pixel_x: 28'd1, pixel_y: 28'd255, zoom_level: 5'd0});

    // random: mostly valid zooms, a tenth past the limit
    for (int n = 0; n < N_RANDOM; n++) begin
      zpick = $urandom_range(0, 9);
      req.zoom_level = (zpick == 0) ? 5'($urandom_range(21, 31)) : 5'($urandom_range(0, 20));
      w = 64'd1 << (TILE_LOG2 + ((req.zoom_level > 20) ? 20 : req.zoom_level));
      req.pixel_x = coord_draw(w);
      req.pixel_y = coord_draw(w);
      pending_reqs.push_back(req);
    end

    // reset held, then released
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_geo.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_geo.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
